### hw/rtl/ple_pkg.sv
package ple_pkg;

	// Field widths of the request and response items.
	localparam int KIND_W   = 3;
	localparam int VAL_W    = 30;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 2;
	localparam int ECNT_W   = 7;

	// Operation codes carried in the kind field.
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;

	// Status codes returned with every response.
	localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_POS   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_LIST_FULL = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [VAL_W-1:0]  item_value;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VAL_W-1:0]    read_value;
		logic [ECNT_W-1:0]   element_count;
	} rsp_t;

	// Controls from the sequencer to the index unit.
	typedef struct packed {
		logic load;
		logic step;
		logic down;
	} idx_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SH_RD,
		ST_SH_WR,
		ST_PUT,
		ST_RD_CAP,
		ST_RESP
	} state_t;

endpackage

### hw/rtl/positional_list_engine.sv
// Positional list engine: an ordered list of up to CAPACITY 30-bit values.
// Requests arrive on the req channel (req_valid, req_stall, req) and each
// carries one operation: push front, push back, insert at a position,
// delete at a position or read at a position. Every request produces one
// response on the rsp channel (rsp_valid, rsp_stall, rsp) with a status,
// the value read and the element count after the operation.
// A transfer happens at a clock edge where valid is high and stall is low.
// The list lives in a single-port-write, single-port-read memory, and the
// elements behind the affected position move one slot at a time, each by a
// read state and then a write state, through one shared index step unit.
// req_stall is high from a request transfer until its response is loaded
// into the output register, so the next request can be taken while a
// response waits. A stalled response holds rsp_valid and rsp; the engine
// then parks until the output register frees. Reset empties the list
// at once; slot contents stay undefined and are never read before
// being written.
module positional_list_engine import ple_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic              ins_q;
	logic [VAL_W-1:0]  val_q;
	logic [STATUS_W-1:0] st_q;
	logic [VAL_W-1:0]  rd_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              accept;
	logic              full;
	logic [CMP_W-1:0]  pos_c, cnt_c;
	logic              dec_ins, dec_del, dec_rd;
	logic [STATUS_W-1:0] dec_status;
	logic [AW-1:0]     dec_start, dec_stop;

	idx_ctl_t          ictl;
	logic [AW-1:0]     idx, nb;
	logic              at_stop;

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [VAL_W-1:0]  mem_wdata, mem_rdata;
	logic              rsp_load;

	ple_mem #(
		.DEPTH(CAPACITY)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ple_idx #(
		.AW(AW)
	) u_idx (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ictl),
		.start_idx (dec_start),
		.stop_idx  (dec_stop),
		.idx       (idx),
		.nb        (nb),
		.at_stop   (at_stop)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	// Decode the incoming request against the current count.
	always_comb begin
		full       = (count_q == CNT_W'(CAPACITY));
		pos_c      = CMP_W'(req.position);
		cnt_c      = CMP_W'(count_q);
		dec_ins    = 1'b0;
		dec_del    = 1'b0;
		dec_rd     = 1'b0;
		dec_status = STATUS_DONE;
		dec_start  = AW'(count_q);
		dec_stop   = AW'(count_q);
		case (req.kind)
			KIND_PUSH_FRONT, KIND_APPEND: begin
				if (full) begin
					dec_status = STATUS_LIST_FULL;
				end else begin
					dec_ins = 1'b1;
					if (req.kind == KIND_PUSH_FRONT) begin
						dec_stop = '0;
					end
				end
			end
			KIND_INSERT: begin
				if (pos_c > cnt_c) begin
					dec_status = STATUS_BAD_POS;
				end else if (full) begin
					dec_status = STATUS_LIST_FULL;
				end else begin
					dec_ins  = 1'b1;
					dec_stop = AW'(req.position);
				end
			end
			KIND_DELETE: begin
				if (pos_c >= cnt_c) begin
					dec_status = STATUS_BAD_POS;
				end else begin
					dec_del   = 1'b1;
					dec_start = AW'(req.position);
					dec_stop  = AW'(count_q - CNT_W'(1));
				end
			end
			KIND_READ: begin
				if (pos_c >= cnt_c) begin
					dec_status = STATUS_BAD_POS;
				end else begin
					dec_rd = 1'b1;
				end
			end
			default: begin
				dec_status = STATUS_DONE;
			end
		endcase
	end

	// Sequencer: next state, memory strobes and index unit controls.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = idx;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = nb;
		ictl      = '0;
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (dec_rd) begin
						mem_re    = 1'b1;
						mem_raddr = AW'(req.position);
						state_d   = ST_RD_CAP;
					end else if (dec_ins || dec_del) begin
						ictl.load = 1'b1;
						ictl.down = dec_ins;
						state_d   = ST_SH_RD;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SH_RD: begin
				if (at_stop) begin
					state_d = ins_q ? ST_PUT : ST_RESP;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_SH_WR;
				end
			end
			ST_SH_WR: begin
				mem_we    = 1'b1;
				ictl.step = 1'b1;
				state_d   = ST_SH_RD;
			end
			ST_PUT: begin
				mem_we    = 1'b1;
				mem_wdata = val_q;
				state_d   = ST_RESP;
			end
			ST_RD_CAP: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register, element count and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && dec_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (accept && dec_del) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Operation payload and the response register.
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q <= dec_ins;
			val_q <= req.item_value;
			st_q  <= dec_status;
			rd_q  <= '0;
		end
		if (state_q == ST_RD_CAP) begin
			rd_q <= mem_rdata;
		end
		if (rsp_load) begin
			rsp_q.status        <= st_q;
			rsp_q.read_value    <= rd_q;
			rsp_q.element_count <= ECNT_W'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1))
			|| (count_q == $past(count_q) - CNT_W'(1)))
		else $error("element count moved by more than one");

	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SH_WR) |-> ($past(state_q) == ST_SH_RD) && $past(mem_re))
		else $error("shift write without a preceding read");

	a_put_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT) |-> (st_q == STATUS_DONE) && ins_q)
		else $error("value written for a rejected operation");
`endif

endmodule

### hw/rtl/ple_mem.sv
module ple_mem import ple_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [VAL_W-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [VAL_W-1:0]         rdata
);

	logic [VAL_W-1:0] mem_q [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/ple_idx.sv
module ple_idx import ple_pkg::*; #(
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  idx_ctl_t      ctl,
	input  logic [AW-1:0] start_idx,
	input  logic [AW-1:0] stop_idx,
	output logic [AW-1:0] idx,
	output logic [AW-1:0] nb,
	output logic          at_stop
);

	logic [AW-1:0] idx_q;
	logic [AW-1:0] stop_q;
	logic          down_q;

	// The shared step unit: one increment or decrement and one compare.
	assign nb      = down_q ? idx_q - AW'(1) : idx_q + AW'(1);
	assign at_stop = (idx_q == stop_q);
	assign idx     = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			stop_q <= '0;
			down_q <= 1'b0;
		end else if (ctl.load) begin
			idx_q  <= start_idx;
			stop_q <= stop_idx;
			down_q <= ctl.down;
		end else if (ctl.step) begin
			idx_q <= nb;
		end
	end

endmodule

### tb/tb_positional_list_engine.sv
module tb_positional_list_engine;
	import ple_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 64;
	localparam int DIRECTED_ITEMS = 25;
	localparam int RANDOM_ITEMS = 1525;
	// Slowest correct run is roughly 1550 items of up to a full-list shift each,
	// plus sender gaps and receiver stalls; the limit is several times that.
	localparam int CYCLE_LIMIT = 1000000;
	// Longest single operation is an insert at the front of a 63-element list.
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_START = 12000;
	localparam int HOLD_CYCLES = 600;
	localparam int MAX_REPORTS = 10;
	// Kinds above read are not operations; the block must leave the list alone.
	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = KIND_READ + 3'd1;
	localparam logic [VAL_W-1:0] VAL_ALL_ONES = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b1;
	rsp_t rsp;

	// Items waiting to be offered, and responses that the list should produce.
	req_t req_todo[$];
	rsp_t rsp_due[$];

	// Shadow copy of the list that the responses are predicted from.
	logic [VAL_W-1:0] list_slot[CAP];
	int list_len = 0;

	// Length tracking used only while building the stimulus.
	int plan_len = 0;

	int reqs_taken = 0;
	int rsps_checked = 0;
	int err_cnt = 0;
	int full_drops = 0;
	int bad_positions = 0;
	int read_hits = 0;
	int spare_kinds = 0;
	int peak_len = 0;
	int burst_left = 0;
	int gap_left = 0;
	int cycles = 0;

	positional_list_engine #(
		.CAPACITY(CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one operation to the shadow list and return the response it should give.
	function automatic rsp_t apply_list_op(req_t r);
		rsp_t o;
		int at;
		int i;
		o = '0;
		o.status = STATUS_DONE;
		at = r.position;
		case (r.kind)
			KIND_PUSH_FRONT, KIND_APPEND, KIND_INSERT: begin
				if (r.kind == KIND_PUSH_FRONT)
					at = 0;
				else if (r.kind == KIND_APPEND)
					at = list_len;
				if (at > list_len) begin
					o.status = STATUS_BAD_POS;
					bad_positions++;
				end else if (list_len >= CAP) begin
					o.status = STATUS_LIST_FULL;
					full_drops++;
				end else begin
					for (i = list_len; i > at; i--)
						list_slot[i] = list_slot[i - 1];
					list_slot[at] = r.item_value;
					list_len++;
				end
			end
			KIND_DELETE: begin
				if (at >= list_len) begin
					o.status = STATUS_BAD_POS;
					bad_positions++;
				end else begin
					for (i = at; i + 1 < list_len; i++)
						list_slot[i] = list_slot[i + 1];
					list_len--;
				end
			end
			KIND_READ: begin
				if (at >= list_len) begin
					o.status = STATUS_BAD_POS;
					bad_positions++;
				end else begin
					o.read_value = list_slot[at];
					read_hits++;
				end
			end
			default: begin
				spare_kinds++;
			end
		endcase
		if (list_len > peak_len)
			peak_len = list_len;
		o.element_count = ECNT_W'(list_len);
		return o;
	endfunction

	// Queue one item and keep the planned length in step with it.
	task automatic add_req(input logic [KIND_W-1:0] k, input logic [VAL_W-1:0] v,
			input logic [POS_W-1:0] p);
		req_t r;
		int at;
		r.kind = k;
		r.item_value = v;
		r.position = p;
		req_todo.insert(req_todo.size(), r);
		at = (k == KIND_PUSH_FRONT) ? 0 : (k == KIND_APPEND) ? plan_len : int'(p);
		if (k == KIND_PUSH_FRONT || k == KIND_APPEND || k == KIND_INSERT) begin
			if (at <= plan_len && plan_len < CAP)
				plan_len++;
		end else if (k == KIND_DELETE && int'(p) < plan_len) begin
			plan_len--;
		end
	endtask

	// Driver: offers queued items in bursts separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else if (!req_valid || !req_stall) begin
			// The last transfer is done or nothing was offered, so choose the next step.
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (req_todo.size() > 0) begin
				req <= req_todo.pop_front();
				req_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls on its own pattern, with one long hold-off that backs up the list.
	int stall_mode = 0;
	int stall_left = 0;
	int hold_left = 0;
	int rx_cycles = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b1;
		end else begin
			rx_cycles++;
			if (rx_cycles == HOLD_START)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				if (stall_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					stall_left = $urandom_range(10, 80);
				end else begin
					stall_left--;
				end
				case (stall_mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					default: rsp_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Monitor: checks each response transfer and predicts each request transfer.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("[%0t] response with nothing expected: status %0d value %h count %0d",
						$realtime, rsp.status, rsp.read_value, rsp.element_count);
			end else begin
				exp_rsp = rsp_due.pop_front();
				rsps_checked++;
				if (rsp.status !== exp_rsp.status || rsp.read_value !== exp_rsp.read_value ||
						rsp.element_count !== exp_rsp.element_count) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("[%0t] mismatch: status %0d/%0d value %h/%h count %0d/%0d (exp/got)",
							$realtime, exp_rsp.status, rsp.status, exp_rsp.read_value,
							rsp.read_value, exp_rsp.element_count, rsp.element_count);
				end
			end
		end
		if (arst_n && req_valid && !req_stall) begin
			rsp_due.insert(rsp_due.size(), apply_list_op(req));
			reqs_taken++;
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		int total;
		int mode;
		int phase_left;
		int roll;
		int hi;
		logic [KIND_W-1:0] k;
		logic [VAL_W-1:0] v;
		logic [POS_W-1:0] p;

		// Directed part: empty-list errors, the value extremes, every operation.
		add_req(KIND_READ, '0, 6'd0);
		add_req(KIND_DELETE, '0, 6'd0);
		add_req(KIND_INSERT, 30'h1234567, 6'd1);
		add_req(KIND_INSERT, '0, 6'd0);
		add_req(KIND_APPEND, VAL_ALL_ONES, 6'd0);
		add_req(KIND_PUSH_FRONT, 30'h2AAAAAAA, 6'd63);
		add_req(KIND_INSERT, 30'h15555555, 6'd1);
		add_req(KIND_INSERT, 30'd123, 6'd4);
		add_req(KIND_INSERT, 30'd77, 6'd6);
		for (int i = 0; i < 6; i++)
			add_req(KIND_READ, '0, POS_W'(i));
		add_req(KIND_READ, VAL_ALL_ONES, 6'd63);
		add_req(KIND_SPARE_FIRST, VAL_ALL_ONES, 6'd63);
		add_req(KIND_SPARE_FIRST + 3'd1, '0, 6'd0);
		add_req(KIND_SPARE_FIRST + 3'd2, VAL_ALL_ONES, 6'd63);
		add_req(KIND_DELETE, '0, 6'd63);
		add_req(KIND_DELETE, '0, 6'd4);
		add_req(KIND_DELETE, '0, 6'd0);
		add_req(KIND_DELETE, '0, 6'd1);
		add_req(KIND_READ, '0, 6'd0);
		add_req(KIND_READ, '0, 6'd1);

		// Random part: phases that grow the list to full, drain it, or mix.
		mode = 0;
		phase_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				mode = $urandom_range(0, 2);
				phase_left = $urandom_range(20, 100);
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			case (mode)
				0: k = (roll < 30) ? KIND_PUSH_FRONT : (roll < 60) ? KIND_APPEND :
					(roll < 88) ? KIND_INSERT : (roll < 93) ? KIND_DELETE :
					(roll < 98) ? KIND_READ : KIND_SPARE_FIRST;
				1: k = (roll < 5) ? KIND_PUSH_FRONT : (roll < 10) ? KIND_APPEND :
					(roll < 15) ? KIND_INSERT : (roll < 75) ? KIND_DELETE :
					(roll < 97) ? KIND_READ : KIND_SPARE_FIRST;
				default: k = (roll < 15) ? KIND_PUSH_FRONT : (roll < 30) ? KIND_APPEND :
					(roll < 50) ? KIND_INSERT : (roll < 75) ? KIND_DELETE :
					(roll < 97) ? KIND_READ : KIND_SPARE_FIRST;
			endcase
			if (k == KIND_SPARE_FIRST)
				k = KIND_SPARE_FIRST + KIND_W'($urandom_range(0, 2));
			roll = $urandom_range(0, 9);
			v = (roll == 0) ? '0 : (roll == 1) ? VAL_ALL_ONES : VAL_W'($urandom());
			// Most positions land inside the list; the rest may fall past its end.
			roll = $urandom_range(0, 99);
			p = POS_W'($urandom_range(0, 63));
			if (k == KIND_INSERT && roll < 88) begin
				hi = (plan_len > 63) ? 63 : plan_len;
				p = POS_W'($urandom_range(0, hi));
			end else if ((k == KIND_DELETE || k == KIND_READ) && plan_len > 0 && roll < 88) begin
				p = POS_W'($urandom_range(0, plan_len - 1));
			end
			add_req(k, v, p);
		end
		total = req_todo.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request and response, then let the block settle.
		while (reqs_taken < total)
			@(negedge clk);
		while (rsp_due.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (rsp_due.size() > 0) begin
			err_cnt++;
			$display("%0d responses never arrived", rsp_due.size());
		end

		$display("Ran %0d list operations and checked %0d responses; longest list %0d.",
			reqs_taken, rsps_checked, peak_len);
		$display("Saw %0d inserts on a full list, %0d bad positions, %0d reads, %0d spare kinds.",
			full_drops, bad_positions, read_hits, spare_kinds);
		if (err_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d errors in total", err_cnt);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
